/* hw/rtl/atrlp_pkg.sv */
// Package for the AT response line parser.
// Parser state codes, result status codes and character constants.
// No dependencies.
package atrlp_pkg;

    typedef enum logic [4:0] {
        S_IDLE     = 5'd0,   // wait for CR
        S_LF1      = 5'd1,   // opening LF
        S_FIRST    = 5'd2,   // first character after opening CR LF
        S_OK_K     = 5'd3,
        S_OK_CR    = 5'd4,
        S_OK_LF    = 5'd5,
        S_ER_R1    = 5'd6,
        S_ER_R2    = 5'd7,
        S_ER_O     = 5'd8,
        S_ER_R3    = 5'd9,
        S_ER_CR    = 5'd10,
        S_ER_LF    = 5'd11,
        S_NAME0    = 5'd12,  // first NAME letter
        S_NAME     = 5'd13,  // more NAME letters or colon
        S_SPACE    = 5'd14,
        S_TEXT0    = 5'd15,  // first text character
        S_TEXT     = 5'd16,  // more text or CR
        S_INFO_LF  = 5'd17,
        S_AFTER    = 5'd18,  // next info line or blank line
        S_BLANK_LF = 5'd19,
        S_FINAL    = 5'd20   // OK or ERROR after the blank line
    } t_parse_state;

    typedef enum logic [1:0] {
        STAT_BUSY  = 2'd0,
        STAT_DONE  = 2'd1,
        STAT_ERROR = 2'd2
    } t_status;

    // Control state carried between the state registers and the step logic
    typedef struct packed {
        t_parse_state st;
        logic         resync;
        logic         cap_en;
        logic         ok;
    } t_ctl;

    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'd126;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_K     = 8'h4B;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] CH_NUL   = 8'h00;

endpackage

/* hw/rtl/atrlp_step.sv */
// Next-state logic of the AT response line parser: one received byte in,
// next parser state, counters and one line-store write out.
// Depends on atrlp_pkg.
module atrlp_step import atrlp_pkg::*; #(
    parameter int MAX_LINES = 16,
    parameter int LINE_SIZE = 128
) (
    input  logic [7:0]                         i_byte,
    input  t_ctl                               i_ctl,
    input  logic [$clog2(MAX_LINES+1)-1:0]     i_line,
    input  logic [$clog2(LINE_SIZE)-1:0]       i_col,
    output t_ctl                               o_ctl,
    output logic [$clog2(MAX_LINES+1)-1:0]     o_line,
    output logic [$clog2(LINE_SIZE)-1:0]       o_col,
    output t_status                            o_status,
    output logic                               o_wr,
    output logic [((MAX_LINES > 1) ? $clog2(MAX_LINES) : 1)-1:0] o_wr_line,
    output logic [$clog2(LINE_SIZE)-1:0]       o_wr_col,
    output logic [7:0]                         o_wr_char
);

    localparam int CNT_W  = $clog2(MAX_LINES + 1);
    localparam int LINE_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int COL_W  = $clog2(LINE_SIZE);
    localparam logic [CNT_W-1:0] MAXL = CNT_W'(MAX_LINES);
    localparam logic [COL_W:0]   LSZ  = (COL_W + 1)'(LINE_SIZE);

    logic             upper;
    logic             printable;
    t_ctl             n_ctl;
    logic [CNT_W-1:0] n_line;
    logic [COL_W:0]   n_col;
    t_status          status;
    logic             cap_req;
    logic [7:0]       cap_char;
    logic             wr;
    logic [LINE_W-1:0] wr_line;
    logic [COL_W-1:0] wr_col;
    logic [7:0]       wr_char;

    assign upper     = (i_byte >= CH_A) && (i_byte <= CH_Z);
    assign printable = (i_byte >= CH_SPACE) && (i_byte <= CH_TILDE);

    always_comb begin
        n_ctl    = i_ctl;
        n_line   = i_line;
        n_col    = {1'b0, i_col};
        status   = STAT_BUSY;
        cap_req  = 1'b0;
        cap_char = i_byte;
        wr       = 1'b0;
        wr_line  = '0;
        wr_col   = '0;
        wr_char  = '0;

        // start of a response
        if (i_ctl.st == S_IDLE || (i_ctl.st == S_LF1 && i_ctl.resync)) begin
            n_ctl.ok     = 1'b1;
            n_line       = '0;
            n_col        = '0;
            n_ctl.cap_en = 1'b1;
        end

        case (i_ctl.st)
            S_IDLE: begin
                if (i_byte == CH_CR) begin
                    n_ctl.st     = S_LF1;
                    n_ctl.resync = 1'b0;
                end
            end
            S_LF1: begin
                if (i_byte == CH_LF) n_ctl.st = S_FIRST;
                else status = STAT_ERROR;
            end
            S_FIRST, S_FINAL: begin
                if (i_byte == CH_O) n_ctl.st = S_OK_K;
                else if (i_byte == CH_E) n_ctl.st = S_ER_R1;
                else if (i_byte == CH_PLUS && i_ctl.st == S_FIRST) begin
                    n_ctl.st = S_NAME0;
                    if (n_ctl.cap_en) begin
                        n_line  = '0;
                        n_col   = '0;
                        cap_req = 1'b1;
                    end
                end else status = STAT_ERROR;
            end
            S_OK_K: begin
                if (i_byte == CH_K) n_ctl.st = S_OK_CR;
                else status = STAT_ERROR;
            end
            S_OK_CR: begin
                if (i_byte == CH_CR) n_ctl.st = S_OK_LF;
                else status = STAT_ERROR;
            end
            S_OK_LF: begin
                if (i_byte == CH_LF) begin
                    n_ctl.ok = 1'b1;
                    status   = STAT_DONE;
                end else status = STAT_ERROR;
            end
            S_ER_R1: begin
                if (i_byte == CH_R) n_ctl.st = S_ER_R2;
                else status = STAT_ERROR;
            end
            S_ER_R2: begin
                if (i_byte == CH_R) n_ctl.st = S_ER_O;
                else status = STAT_ERROR;
            end
            S_ER_O: begin
                if (i_byte == CH_O) n_ctl.st = S_ER_R3;
                else status = STAT_ERROR;
            end
            S_ER_R3: begin
                if (i_byte == CH_R) n_ctl.st = S_ER_CR;
                else status = STAT_ERROR;
            end
            S_ER_CR: begin
                if (i_byte == CH_CR) n_ctl.st = S_ER_LF;
                else status = STAT_ERROR;
            end
            S_ER_LF: begin
                if (i_byte == CH_LF) begin
                    n_ctl.ok = 1'b0;
                    status   = STAT_DONE;
                end else status = STAT_ERROR;
            end
            S_NAME0: begin
                if (upper) begin
                    n_ctl.st = S_NAME;
                    cap_req  = 1'b1;
                end else status = STAT_ERROR;
            end
            S_NAME: begin
                if (upper) cap_req = 1'b1;
                else if (i_byte == CH_COLON) begin
                    n_ctl.st = S_SPACE;
                    cap_req  = 1'b1;
                end else status = STAT_ERROR;
            end
            S_SPACE: begin
                if (i_byte == CH_SPACE) begin
                    n_ctl.st = S_TEXT0;
                    cap_req  = 1'b1;
                end else status = STAT_ERROR;
            end
            S_TEXT0: begin
                if (printable) begin
                    n_ctl.st = S_TEXT;
                    cap_req  = 1'b1;
                end else status = STAT_ERROR;
            end
            S_TEXT: begin
                if (printable) cap_req = 1'b1;
                else if (i_byte == CH_CR) n_ctl.st = S_INFO_LF;
                else status = STAT_ERROR;
            end
            S_INFO_LF: begin
                if (i_byte == CH_LF) begin
                    n_ctl.st = S_AFTER;
                    cap_req  = 1'b1;
                    cap_char = CH_NUL;
                end else status = STAT_ERROR;
            end
            S_AFTER: begin
                if (i_byte == CH_CR) begin
                    n_ctl.st = S_BLANK_LF;
                    if (n_ctl.cap_en) begin
                        // terminate the line, then move to the next row
                        if (n_line < MAXL) begin
                            wr      = 1'b1;
                            wr_line = n_line[LINE_W-1:0];
                            wr_col  = n_col[COL_W-1:0];
                            wr_char = CH_NUL;
                        end
                        if (n_line < MAXL) n_line = n_line + 1'b1;
                        n_col = '0;
                    end
                end else if (i_byte == CH_PLUS) begin
                    n_ctl.st = S_NAME0;
                    if (n_ctl.cap_en) begin
                        if (n_line < MAXL) n_line = n_line + 1'b1;
                        n_col   = '0;
                        cap_req = 1'b1;
                    end
                end else status = STAT_ERROR;
            end
            S_BLANK_LF: begin
                if (i_byte == CH_LF) n_ctl.st = S_FINAL;
                else status = STAT_ERROR;
            end
            default: begin
                n_ctl.st = S_IDLE;
            end
        endcase

        // store one character and advance the column
        if (cap_req && n_ctl.cap_en) begin
            if (n_line < MAXL) begin
                wr      = 1'b1;
                wr_line = n_line[LINE_W-1:0];
                wr_col  = n_col[COL_W-1:0];
                wr_char = cap_char;
            end
            n_col = n_col + 1'b1;
        end

        if (n_col >= LSZ) n_col = '0;
        if (n_line >= MAXL) n_ctl.cap_en = 1'b0;

        if (status == STAT_ERROR) begin
            n_ctl.ok = 1'b0;
            if (n_line < MAXL) begin
                wr      = 1'b1;
                wr_line = n_line[LINE_W-1:0];
                wr_col  = n_col[COL_W-1:0];
                wr_char = CH_NUL;
            end
            if (n_line < MAXL) n_line = n_line + 1'b1;
            n_ctl.st = S_IDLE;
            // a CR that breaks the form opens the next response
            if (i_byte == CH_CR) begin
                n_ctl.st     = S_LF1;
                n_ctl.resync = 1'b1;
            end
        end else if (status == STAT_DONE) begin
            n_ctl.st = S_IDLE;
        end
    end

    assign o_ctl     = n_ctl;
    assign o_line    = n_line;
    assign o_col     = n_col[COL_W-1:0];
    assign o_status  = status;
    assign o_wr      = wr;
    assign o_wr_line = wr_line;
    assign o_wr_col  = wr_col;
    assign o_wr_char = wr_char;

endmodule

/* hw/rtl/at_response_line_parser.sv */
// Top level of the AT response line parser: input register, parser state,
// result register. Depends on atrlp_pkg and atrlp_step.
//
//   channel   direction  handshake                 payload
//   rx        in         i_rx_valid / o_rx_stall   i_rx_byte
//   res       out        o_res_valid / i_res_stall o_status, o_response_ok,
//                                                  o_lines_captured, o_store_*
//
// One item per cycle when no stall holds the flow; an accepted item is held in the
// input register, and its result is then loaded into the result register. Parser
// state updates when an item moves from the input register into the result
// register. A stall on the result side holds the result register; once the input
// register is also full, the input stalls.
// Synchronous active-low reset returns the parser to waiting for CR.
module at_response_line_parser import atrlp_pkg::*; #(
    parameter int MAX_LINES = 16,
    parameter int LINE_SIZE = 128
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_rx_valid,
    output logic                                o_rx_stall,
    input  logic [7:0]                          i_rx_byte,
    output logic                                o_res_valid,
    input  logic                                i_res_stall,
    output logic [1:0]                          o_status,
    output logic                                o_response_ok,
    output logic [$clog2(MAX_LINES+1)-1:0]      o_lines_captured,
    output logic                                o_store_write,
    output logic [((MAX_LINES > 1) ? $clog2(MAX_LINES) : 1)-1:0] o_store_line,
    output logic [$clog2(LINE_SIZE)-1:0]        o_store_column,
    output logic [7:0]                          o_store_char
);

    localparam int CNT_W  = $clog2(MAX_LINES + 1);
    localparam int LINE_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int COL_W  = $clog2(LINE_SIZE);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    t_ctl              r_ctl;
    logic [CNT_W-1:0]  r_line;
    logic [COL_W-1:0]  r_col;
    logic              r_out_valid;
    t_status           r_status;
    logic              r_ok;
    logic [CNT_W-1:0]  r_lines;
    logic              r_wr;
    logic [LINE_W-1:0] r_wr_line;
    logic [COL_W-1:0]  r_wr_col;
    logic [7:0]        r_wr_char;

    t_ctl              n_ctl;
    logic [CNT_W-1:0]  n_line;
    logic [COL_W-1:0]  n_col;
    t_status           n_status;
    logic              n_wr;
    logic [LINE_W-1:0] n_wr_line;
    logic [COL_W-1:0]  n_wr_col;
    logic [7:0]        n_wr_char;

    logic out_free;
    logic step;
    logic in_load;

    assign out_free   = !r_out_valid || !i_res_stall;
    assign step       = r_in_valid && out_free;
    assign o_rx_stall = r_in_valid && !out_free;
    assign in_load    = i_rx_valid && !o_rx_stall;

    atrlp_step #(
        .MAX_LINES (MAX_LINES),
        .LINE_SIZE (LINE_SIZE)
    ) u_step (
        .i_byte    (r_in_byte),
        .i_ctl     (r_ctl),
        .i_line    (r_line),
        .i_col     (r_col),
        .o_ctl     (n_ctl),
        .o_line    (n_line),
        .o_col     (n_col),
        .o_status  (n_status),
        .o_wr      (n_wr),
        .o_wr_line (n_wr_line),
        .o_wr_col  (n_wr_col),
        .o_wr_char (n_wr_char)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_ctl.st     <= S_IDLE;
            r_ctl.resync <= 1'b0;
            r_ctl.cap_en <= 1'b1;
            r_ctl.ok     <= 1'b0;
            r_line       <= '0;
            r_col        <= '0;
        end else begin
            if (in_load) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (step) begin
                r_ctl  <= n_ctl;
                r_line <= n_line;
                r_col  <= n_col;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_in_byte <= i_rx_byte;
        end
        if (step) begin
            r_status  <= n_status;
            r_ok      <= n_ctl.ok;
            r_lines   <= n_line;
            r_wr      <= n_wr;
            r_wr_line <= n_wr_line;
            r_wr_col  <= n_wr_col;
            r_wr_char <= n_wr_char;
        end
    end

    assign o_res_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_response_ok    = r_ok;
    assign o_lines_captured = r_lines;
    assign o_store_write    = r_wr;
    assign o_store_line     = r_wr_line;
    assign o_store_column   = r_wr_col;
    assign o_store_char     = r_wr_char;

endmodule

/* sim/testbench.sv */
// Testbench for at_response_line_parser: feeds modem response bytes and checks every
// result against a cycle-free predictor of the parser, with random idling on both sides.
// Depends on atrlp_pkg and the at_response_line_parser RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import atrlp_pkg::*;

    localparam int MAX_ROWS = 16;
    localparam int ROW_LEN  = 128;

    typedef struct packed {
        t_status    status;
        logic       ok;
        logic [4:0] lines;
        logic       wr;
        logic [3:0] row;
        logic [6:0] col;
        logic [7:0] ch;
    } t_parse_result;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_rx_valid = 1'b0;
    logic [7:0] i_rx_byte = 8'h00;
    logic       i_res_stall = 1'b0;
    logic       o_rx_stall;
    logic       o_res_valid;
    logic [1:0] o_status;
    logic       o_response_ok;
    logic [4:0] o_lines_captured;
    logic       o_store_write;
    logic [3:0] o_store_line;
    logic [6:0] o_store_column;
    logic [7:0] o_store_char;

    // Predictor state, reset values
    t_parse_state pr_state  = S_IDLE;
    int           pr_col    = 0;
    int           pr_lines  = 0;
    bit           pr_resync = 1'b0;
    bit           pr_cap    = 1'b1;
    bit           pr_ok     = 1'b0;

    t_parse_result parse_results[$];
    logic [7:0]    frame[$];
    int            fail_count  = 0;
    int            hold_cycles = 0;
    bit            tx_steady   = 1'b0;
    bit            rx_steady   = 1'b0;

    at_response_line_parser #(
        .MAX_LINES(MAX_ROWS),
        .LINE_SIZE(ROW_LEN)
    ) uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_rx_valid       (i_rx_valid),
        .o_rx_stall       (o_rx_stall),
        .i_rx_byte        (i_rx_byte),
        .o_res_valid      (o_res_valid),
        .i_res_stall      (i_res_stall),
        .o_status         (o_status),
        .o_response_ok    (o_response_ok),
        .o_lines_captured (o_lines_captured),
        .o_store_write    (o_store_write),
        .o_store_line     (o_store_line),
        .o_store_column   (o_store_column),
        .o_store_char     (o_store_char)
    );

    always #6 i_clk = ~i_clk;

    // ---------------- predictor ----------------

    function automatic void store_byte(inout t_parse_result r, input logic [7:0] ch);
        if (pr_lines < MAX_ROWS) begin
            r.wr  = 1'b1;
            r.row = 4'(pr_lines);
            r.col = 7'(pr_col);
            r.ch  = ch;
        end
    endfunction

    function automatic void keep_byte(inout t_parse_result r, input logic [7:0] ch);
        if (pr_cap) begin
            store_byte(r, ch);
            pr_col++;
        end
    endfunction

    function automatic void advance_row();
        if (pr_lines < MAX_ROWS)
            pr_lines++;
        pr_col = 0;
    endfunction

    function automatic t_parse_result parse_byte(input logic [7:0] c);
        t_parse_result r;
        t_parse_state  st;
        t_status       stat;
        bit            is_upper;
        bit            is_print;
        r        = '0;
        st       = pr_state;
        stat     = STAT_BUSY;
        is_upper = (c >= CH_A && c <= CH_Z);
        is_print = (c >= CH_SPACE && c <= CH_TILDE);

        // a new response starts here
        if (st == S_IDLE || (st == S_LF1 && pr_resync)) begin
            pr_ok    = 1'b1;
            pr_lines = 0;
            pr_col   = 0;
            pr_cap   = 1'b1;
        end

        case (st)
            S_IDLE: begin
                if (c == CH_CR) begin
                    st = S_LF1;
                    pr_resync = 1'b0;
                end
            end
            S_LF1: if (c == CH_LF) st = S_FIRST; else stat = STAT_ERROR;
            S_FIRST, S_FINAL: begin
                if (c == CH_O) st = S_OK_K;
                else if (c == CH_E) st = S_ER_R1;
                else if (c == CH_PLUS && st == S_FIRST) begin
                    st = S_NAME0;
                    if (pr_cap) begin
                        pr_lines = 0;
                        pr_col   = 0;
                        keep_byte(r, c);
                    end
                end else stat = STAT_ERROR;
            end
            S_OK_K:  if (c == CH_K) st = S_OK_CR; else stat = STAT_ERROR;
            S_OK_CR: if (c == CH_CR) st = S_OK_LF; else stat = STAT_ERROR;
            S_OK_LF: begin
                if (c == CH_LF) begin
                    pr_ok = 1'b1;
                    stat  = STAT_DONE;
                end else stat = STAT_ERROR;
            end
            S_ER_R1: if (c == CH_R) st = S_ER_R2; else stat = STAT_ERROR;
            S_ER_R2: if (c == CH_R) st = S_ER_O; else stat = STAT_ERROR;
            S_ER_O:  if (c == CH_O) st = S_ER_R3; else stat = STAT_ERROR;
            S_ER_R3: if (c == CH_R) st = S_ER_CR; else stat = STAT_ERROR;
            S_ER_CR: if (c == CH_CR) st = S_ER_LF; else stat = STAT_ERROR;
            S_ER_LF: begin
                if (c == CH_LF) begin
                    pr_ok = 1'b0;
                    stat  = STAT_DONE;
                end else stat = STAT_ERROR;
            end
            S_NAME0: begin
                if (is_upper) begin
                    st = S_NAME;
                    keep_byte(r, c);
                end else stat = STAT_ERROR;
            end
            S_NAME: begin
                if (is_upper) keep_byte(r, c);
                else if (c == CH_COLON) begin
                    st = S_SPACE;
                    keep_byte(r, c);
                end else stat = STAT_ERROR;
            end
            S_SPACE: begin
                if (c == CH_SPACE) begin
                    st = S_TEXT0;
                    keep_byte(r, c);
                end else stat = STAT_ERROR;
            end
            S_TEXT0: begin
                if (is_print) begin
                    st = S_TEXT;
                    keep_byte(r, c);
                end else stat = STAT_ERROR;
            end
            S_TEXT: begin
                if (is_print) keep_byte(r, c);
                else if (c == CH_CR) st = S_INFO_LF;
                else stat = STAT_ERROR;
            end
            S_INFO_LF: begin
                if (c == CH_LF) begin
                    st = S_AFTER;
                    keep_byte(r, CH_NUL);
                end else stat = STAT_ERROR;
            end
            S_AFTER: begin
                if (c == CH_CR) begin
                    st = S_BLANK_LF;
                    if (pr_cap) begin
                        store_byte(r, CH_NUL);
                        advance_row();
                    end
                end else if (c == CH_PLUS) begin
                    st = S_NAME0;
                    if (pr_cap) begin
                        advance_row();
                        keep_byte(r, c);
                    end
                end else stat = STAT_ERROR;
            end
            S_BLANK_LF: if (c == CH_LF) st = S_FINAL; else stat = STAT_ERROR;
            default: st = S_IDLE;
        endcase

        if (pr_col >= ROW_LEN)
            pr_col = 0;
        if (pr_lines >= MAX_ROWS)
            pr_cap = 1'b0;

        if (stat == STAT_ERROR) begin
            pr_ok = 1'b0;
            store_byte(r, CH_NUL);
            if (pr_lines < MAX_ROWS)
                pr_lines++;
            st = S_IDLE;
            // a bad CR opens the next response
            if (c == CH_CR) begin
                st = S_LF1;
                pr_resync = 1'b1;
            end
        end else if (stat == STAT_DONE) begin
            st = S_IDLE;
        end
        pr_state = st;

        r.status = stat;
        r.ok     = pr_ok;
        r.lines  = 5'(pr_lines);
        return r;
    endfunction

    // ---------------- checking ----------------

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endtask

    task automatic check_result();
        t_parse_result e;
        if (parse_results.size() == 0) begin
            note_failure($sformatf("unexpected result: status %0d lines %0d",
                                   o_status, o_lines_captured));
        end else begin
            e = parse_results.pop_front();
            if (o_status !== e.status || o_response_ok !== e.ok ||
                o_lines_captured !== e.lines || o_store_write !== e.wr ||
                o_store_line !== e.row || o_store_column !== e.col ||
                o_store_char !== e.ch)
                note_failure($sformatf({
                    "result mismatch: exp st=%0d ok=%0d lines=%0d wr=%0d row=%0d ",
                    "col=%0d ch=%02h, got st=%0d ok=%0d lines=%0d wr=%0d row=%0d ",
                    "col=%0d ch=%02h"},
                    e.status, e.ok, e.lines, e.wr, e.row, e.col, e.ch,
                    o_status, o_response_ok, o_lines_captured, o_store_write,
                    o_store_line, o_store_column, o_store_char));
        end
    endtask

    // Sample at the falling edge, where the result is stable; drive stall at the rising edge
    always begin
        @(negedge i_clk);
        if (i_rst_n && o_res_valid && !i_res_stall)
            check_result();
        @(posedge i_clk);
        if (hold_cycles > 0) begin
            i_res_stall <= 1'b1;
            hold_cycles--;
        end else begin
            i_res_stall <= !rx_steady && ($urandom_range(99) < 37);
        end
    end

    // ---------------- stimulus helpers ----------------

    task automatic send_byte(input logic [7:0] b);
        bit taken;
        if (!tx_steady)
            while ($urandom_range(99) < 37) begin
                i_rx_valid <= 1'b0;
                @(posedge i_clk);
            end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        do begin
            @(negedge i_clk);
            taken = !o_rx_stall;
            @(posedge i_clk);
        end while (!taken);
        parse_results.push_back(parse_byte(b));
    endtask

    task automatic send_frame();
        foreach (frame[i])
            send_byte(frame[i]);
        frame.delete();
    endtask

    task automatic wait_drained();
        i_rx_valid <= 1'b0;
        while (parse_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic add_crlf();
        frame.push_back(CH_CR);
        frame.push_back(CH_LF);
    endtask

    task automatic add_final(input bit is_ok);
        if (is_ok) begin
            frame.push_back(CH_O);
            frame.push_back(CH_K);
        end else begin
            frame.push_back(CH_E);
            frame.push_back(CH_R);
            frame.push_back(CH_R);
            frame.push_back(CH_O);
            frame.push_back(CH_R);
        end
        add_crlf();
    endtask

    task automatic add_info_line(input int text_len);
        int name_len;
        name_len = $urandom_range(1, 6);
        frame.push_back(CH_PLUS);
        repeat (name_len) frame.push_back(8'($urandom_range(CH_A, CH_Z)));
        frame.push_back(CH_COLON);
        frame.push_back(CH_SPACE);
        repeat (text_len) frame.push_back(8'($urandom_range(CH_SPACE, CH_TILDE)));
        add_crlf();
    endtask

    task automatic add_response(input int n_lines, input int text_max, input bit is_ok);
        add_crlf();
        repeat (n_lines) add_info_line($urandom_range(1, text_max));
        if (n_lines > 0)
            add_crlf();
        add_final(is_ok);
    endtask

    task automatic add_random_response();
        int pick;
        int n_lines;
        int text_max;
        pick     = $urandom_range(99);
        n_lines  = (pick < 30) ? 0 : (pick < 94) ? $urandom_range(1, 4) : $urandom_range(14, 19);
        text_max = ($urandom_range(99) < 5) ? 200 : 12;
        add_response(n_lines, text_max, $urandom_range(1));
    endtask

    // Break the frame: overwrite, drop or cut off at one position
    task automatic corrupt_frame();
        int idx;
        idx = $urandom_range(frame.size() - 1);
        case ($urandom_range(2))
            0: frame[idx] = ($urandom_range(3) == 0) ? CH_CR : 8'($urandom_range(255));
            1: frame.delete(idx);
            default: while (frame.size() > idx) void'(frame.pop_back());
        endcase
    endtask

    // ---------------- tests ----------------

    task automatic test_idle_bytes();
        frame = '{8'h00, 8'hFF, CH_LF};
        send_frame();
    endtask

    task automatic test_final_codes();
        add_response(0, 1, 1'b1);
        add_response(0, 1, 1'b0);
        send_frame();
    endtask

    // CR inside OK restarts the response; the restarted one then completes
    task automatic test_resync();
        add_crlf();
        frame.push_back(CH_O);
        add_crlf();
        add_final(1'b1);
        send_frame();
    endtask

    task automatic test_column_wrap();
        add_crlf();
        add_info_line(140);
        add_info_line(260);
        add_crlf();
        add_final(1'b0);
        send_frame();
    endtask

    task automatic test_line_limit();
        add_response(18, 4, 1'b1);
        // error past the limit: no terminator write, count stays saturated
        add_crlf();
        repeat (17) add_info_line($urandom_range(1, 4));
        frame.push_back(8'h58);
        send_frame();
    endtask

    task automatic test_backpressure();
        hold_cycles = 60;
        tx_steady   = 1'b1;
        add_response(3, 8, 1'b1);
        send_frame();
        tx_steady = 1'b0;
        wait_drained();
        add_response(1, 6, 1'b0);
        send_frame();
    endtask

    task automatic test_random_traffic();
        int sent;
        int pick;
        sent      = 0;
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        while (sent < 400) begin
            if (sent >= 200) begin
                tx_steady = 1'b0;
                rx_steady = 1'b0;
            end
            pick = $urandom_range(99);
            if (pick < 15) begin
                repeat ($urandom_range(1, 6)) frame.push_back(8'($urandom_range(255)));
                send_frame();
            end else begin
                add_random_response();
                if (pick < 35)
                    corrupt_frame();
                sent += frame.size();
                send_frame();
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_idle_bytes();
        test_final_codes();
        test_resync();
        test_column_wrap();
        test_line_limit();
        test_backpressure();
        test_random_traffic();
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("[at_response_line_parser] OK");
        else
            $display("[at_response_line_parser] ERROR");
        $finish;
    end

    initial begin
        #3_000_000;
        $display("[at_response_line_parser] ERROR");
        $finish;
    end

endmodule
